### hdl/bbrb_pkg.sv
package bbrb_pkg;

  localparam int CAPACITY    = 4096;
  localparam int MAX_REQUEST = 64;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int SIZE_W      = ADDR_W + 1;
  localparam int LEN_W       = 7;
  localparam int MODE_W      = 3;
  localparam int QDEPTH      = 2;

  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_NOALLOC = 2'd2;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_PEEK,
    OP_REMOVE,
    OP_QUERY
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
    logic             first;
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_XFER,
    S_COMPACT
  } back_state_t;

endpackage

### hdl/bbrb_front.sv
module bbrb_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bbrb_pkg::MODE_W-1:0]   mode,
  input  logic [bbrb_pkg::LEN_W-1:0]    length,
  input  logic [7:0]                    data_byte,
  input  logic                          first,
  output logic                          q_valid,
  output bbrb_pkg::op_t                 q_op,
  input  logic                          q_pop
);

  bbrb_pkg::op_t                        entry [bbrb_pkg::QDEPTH];
  logic                                 wr_ptr, rd_ptr;
  logic [1:0]                           fill_cnt;
  bbrb_pkg::op_t                        dec;
  logic                                 push;

  // classify the item and cap its length
  always_comb begin
    unique case (mode)
      bbrb_pkg::MODE_WRITE:  dec.kind = bbrb_pkg::OP_WRITE;
      bbrb_pkg::MODE_READ:   dec.kind = bbrb_pkg::OP_READ;
      bbrb_pkg::MODE_PEEK:   dec.kind = bbrb_pkg::OP_PEEK;
      bbrb_pkg::MODE_REMOVE: dec.kind = bbrb_pkg::OP_REMOVE;
      default:               dec.kind = bbrb_pkg::OP_QUERY;
    endcase
    dec.len   = (length > bbrb_pkg::LEN_W'(bbrb_pkg::MAX_REQUEST))
                ? bbrb_pkg::LEN_W'(bbrb_pkg::MAX_REQUEST) : length;
    dec.data  = data_byte;
    dec.first = first;
  end

  assign busy    = (fill_cnt == 2'(bbrb_pkg::QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill_cnt != 2'd0);
  assign q_op    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fill_cnt <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill_cnt <= fill_cnt + 2'(push) - 2'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill_cnt <= 2'(bbrb_pkg::QDEPTH))
    else $error("queue overflow");
  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    (busy && !q_pop) |=> busy)
    else $error("busy dropped without a pop");

endmodule

### hdl/bbrb_back.sv
module bbrb_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bbrb_pkg::SIZE_W-1:0]   cfg_wdata,
  input  logic                          q_valid,
  input  bbrb_pkg::op_t                 q_op,
  output logic                          q_pop,
  output logic                          strobe,
  output logic [7:0]                    out_byte,
  output logic                          byte_valid,
  output logic                          last,
  output logic [1:0]                    status,
  output logic [bbrb_pkg::LEN_W-1:0]    count,
  output logic [bbrb_pkg::SIZE_W-1:0]   space,
  output logic [bbrb_pkg::SIZE_W-1:0]   fill,
  output logic [bbrb_pkg::SIZE_W-1:0]   contiguous
);

  localparam int AW = bbrb_pkg::ADDR_W;
  localparam int SW = bbrb_pkg::SIZE_W;
  localparam int LW = bbrb_pkg::LEN_W;

  logic [7:0]    mem [bbrb_pkg::CAPACITY];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data;
  logic          wr_en;

  bbrb_pkg::back_state_t state, state_next;

  logic [SW-1:0] buffer_size;
  logic [AW-1:0] a_start, a_start_next, b_start, b_start_next;
  logic [SW-1:0] a_size, a_size_next, b_size, b_size_next;
  logic          b_active, b_active_next;
  logic          write_ok, write_ok_next, write_to_b, write_to_b_next;
  logic [LW-1:0] write_left, write_left_next;

  logic [LW-1:0] xk, xk_next, xn, xn_next, xt, xt_next;
  logic [AW-1:0] xa, xa_next, xb, xb_next;
  logic          cmp_go, cmp_go_next;
  logic [AW-1:0] csrc, csrc_next;
  logic [SW-1:0] ci, ci_next, ccnt, ccnt_next;
  logic          cpend, cpend_next;
  logic [AW-1:0] cdst, cdst_next;

  logic          res_v, res_v_next, res_bv, res_bv_next, res_last, res_last_next;
  logic [1:0]    res_st, res_st_next;
  logic [LW-1:0] res_cnt, res_cnt_next;

  logic [SW-1:0] eff, held, a_end, b_end, fa, fb, sp_now;
  logic          alloc, tb_now;

  // free space and target region of the next write
  always_comb begin
    eff    = (buffer_size > SW'(bbrb_pkg::CAPACITY)) ? SW'(bbrb_pkg::CAPACITY) : buffer_size;
    alloc  = (eff != '0);
    held   = a_size + b_size;
    a_end  = SW'(a_start) + a_size;
    b_end  = SW'(b_start) + b_size;
    fa     = (a_end >= eff) ? '0 : eff - a_end;
    fb     = (b_end >= SW'(a_start)) ? '0 : SW'(a_start) - b_end;
    if (b_active) begin
      tb_now = 1'b1;
      sp_now = fb;
    end else if (fa < SW'(a_start)) begin
      tb_now = 1'b1;
      sp_now = SW'(a_start);
    end else begin
      tb_now = 1'b0;
      sp_now = fa;
    end
  end

  assign q_pop = (state == bbrb_pkg::S_IDLE) && q_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      bbrb_pkg::S_IDLE: begin
        if (q_pop && alloc && (q_op.kind == bbrb_pkg::OP_READ ||
            q_op.kind == bbrb_pkg::OP_PEEK) && xn_next != '0) begin
          state_next = bbrb_pkg::S_XFER;
        end else if (cmp_go_next) begin
          state_next = bbrb_pkg::S_COMPACT;
        end
      end
      bbrb_pkg::S_XFER: begin
        if (xk == xn - LW'(1)) begin
          state_next = cmp_go ? bbrb_pkg::S_COMPACT : bbrb_pkg::S_IDLE;
        end
      end
      bbrb_pkg::S_COMPACT: begin
        if (ci == ccnt && !cpend) begin
          state_next = bbrb_pkg::S_IDLE;
        end
      end
      default: state_next = bbrb_pkg::S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    logic [LW-1:0] n, t, rem;
    logic          ok;
    logic [LW-1:0] left;
    logic          tob;
    logic [SW-1:0] asz_n, bsz_n;
    logic [AW-1:0] ast_n, bst_n;

    a_start_next = a_start;   a_size_next = a_size;
    b_start_next = b_start;   b_size_next = b_size;
    b_active_next = b_active;
    write_ok_next = write_ok; write_to_b_next = write_to_b;
    write_left_next = write_left;
    xk_next = xk; xn_next = xn; xt_next = xt; xa_next = xa; xb_next = xb;
    cmp_go_next = cmp_go; csrc_next = csrc; ccnt_next = ccnt; ci_next = ci;
    cpend_next = 1'b0; cdst_next = cdst;
    res_v_next = 1'b0; res_bv_next = 1'b0; res_last_next = 1'b1;
    res_st_next = bbrb_pkg::ST_OK; res_cnt_next = '0;
    rd_addr = '0; wr_addr = '0; wr_data = q_op.data; wr_en = 1'b0;
    n = '0; t = '0; rem = '0; ok = write_ok; left = write_left; tob = write_to_b;
    asz_n = a_size; bsz_n = b_size; ast_n = a_start; bst_n = b_start;

    unique case (state)
      bbrb_pkg::S_IDLE: begin
        if (q_pop) begin
          res_v_next = 1'b1;
          if (!alloc) begin
            res_st_next = bbrb_pkg::ST_NOALLOC;
          end else begin
            unique case (q_op.kind)
              bbrb_pkg::OP_WRITE: begin
                priority if (q_op.first && sp_now < SW'(q_op.len)) begin
                  write_ok_next = 1'b0; write_left_next = '0;
                  res_st_next = bbrb_pkg::ST_SHORT;
                end else if (q_op.first && q_op.len == '0) begin
                  write_ok_next = 1'b0; write_left_next = '0;
                end else begin
                  if (q_op.first) begin
                    ok = 1'b1; left = q_op.len; tob = tb_now;
                    if (tb_now && !b_active) begin
                      b_active_next = 1'b1; bst_n = '0; bsz_n = '0;
                    end
                  end
                  if (!ok || left == '0) begin
                    write_ok_next = 1'b0;
                    res_st_next = bbrb_pkg::ST_SHORT;
                  end else begin
                    wr_en = 1'b1;
                    if (tob) begin
                      wr_addr = bst_n + AW'(bsz_n);
                      bsz_n = bsz_n + SW'(1);
                    end else begin
                      wr_addr = a_start + AW'(a_size);
                      asz_n = a_size + SW'(1);
                    end
                    write_left_next = left - LW'(1);
                    write_ok_next = (left != LW'(1));
                    write_to_b_next = tob;
                  end
                  a_size_next = asz_n; b_size_next = bsz_n; b_start_next = bst_n;
                end
              end
              bbrb_pkg::OP_READ, bbrb_pkg::OP_PEEK, bbrb_pkg::OP_REMOVE: begin
                if (q_op.kind == bbrb_pkg::OP_READ && held < SW'(q_op.len)) begin
                  res_st_next = bbrb_pkg::ST_SHORT;
                  xn_next = '0;
                end else begin
                  n = (SW'(q_op.len) < held) ? q_op.len : LW'(held);
                  t = (SW'(n) < a_size) ? n : LW'(a_size);
                  rem = n - t;
                  xk_next = '0; xn_next = n; xt_next = t;
                  xa_next = a_start; xb_next = b_start;
                  cmp_go_next = 1'b0;
                  if (q_op.kind != bbrb_pkg::OP_PEEK) begin
                    ast_n = a_start + AW'(t);
                    asz_n = a_size - SW'(t);
                    bst_n = b_start + AW'(rem);
                    bsz_n = b_size - SW'(rem);
                    if (asz_n == '0) begin
                      cmp_go_next = (bsz_n != '0);
                      csrc_next = bst_n; ccnt_next = bsz_n; ci_next = '0;
                      asz_n = bsz_n; ast_n = '0; bst_n = '0; bsz_n = '0;
                      b_active_next = 1'b0;
                    end
                    a_start_next = ast_n; a_size_next = asz_n;
                    b_start_next = bst_n; b_size_next = bsz_n;
                  end
                  if (q_op.kind != bbrb_pkg::OP_REMOVE && n != '0) begin
                    res_v_next = 1'b0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      bbrb_pkg::S_XFER: begin
        rd_addr = (xk < xt) ? xa + AW'(xk) : xb + AW'(xk - xt);
        res_v_next = 1'b1; res_bv_next = 1'b1; res_cnt_next = xn;
        res_last_next = (xk == xn - LW'(1));
        xk_next = xk + LW'(1);
        ci_next = '0;
      end
      bbrb_pkg::S_COMPACT: begin
        rd_addr = csrc + AW'(ci);
        if (ci != ccnt) begin
          ci_next = ci + SW'(1);
          cpend_next = 1'b1;
          cdst_next = AW'(ci);
        end
        if (cpend) begin
          wr_en = 1'b1; wr_addr = cdst; wr_data = rd_data;
        end
        if (ci == ccnt && !cpend) begin
          cmp_go_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    xk <= xk_next; xn <= xn_next; xt <= xt_next; xa <= xa_next; xb <= xb_next;
    csrc <= csrc_next; ccnt <= ccnt_next; ci <= ci_next; cdst <= cdst_next;
    res_bv <= res_bv_next; res_last <= res_last_next; res_st <= res_st_next;
    res_cnt <= res_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbrb_pkg::S_IDLE;
      buffer_size <= '0;
      a_start <= '0; a_size <= '0; b_start <= '0; b_size <= '0; b_active <= 1'b0;
      write_ok <= 1'b0; write_to_b <= 1'b0; write_left <= '0;
      cmp_go <= 1'b0; cpend <= 1'b0; res_v <= 1'b0;
    end else if (cfg_we) begin
      buffer_size <= cfg_wdata;
      a_start <= '0; a_size <= '0; b_start <= '0; b_size <= '0; b_active <= 1'b0;
      write_ok <= 1'b0; write_to_b <= 1'b0; write_left <= '0;
      state <= bbrb_pkg::S_IDLE; cmp_go <= 1'b0; cpend <= 1'b0; res_v <= 1'b0;
    end else begin
      state <= state_next;
      a_start <= a_start_next; a_size <= a_size_next;
      b_start <= b_start_next; b_size <= b_size_next; b_active <= b_active_next;
      write_ok <= write_ok_next; write_to_b <= write_to_b_next;
      write_left <= write_left_next;
      cmp_go <= cmp_go_next; cpend <= cpend_next; res_v <= res_v_next;
    end
  end

  assign strobe     = res_v;
  assign byte_valid = res_bv;
  assign out_byte   = res_bv ? rd_data : 8'd0;
  assign last       = res_last;
  assign status     = res_st;
  assign count      = res_cnt;
  assign space      = alloc ? sp_now : '0;
  assign fill       = alloc ? held : '0;
  assign contiguous = alloc ? ((a_size != '0) ? a_size : b_size) : '0;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    alloc |-> (held <= eff))
    else $error("held bytes exceed buffer size");
  a_b_needs_a: assert property (@(posedge clk) disable iff (rst)
    b_active |-> (a_size != '0))
    else $error("region b active with region a empty");
  a_no_result_compact: assert property (@(posedge clk) disable iff (rst)
    $past(state) == bbrb_pkg::S_COMPACT && !$past(cfg_we) |-> !strobe)
    else $error("result during compaction");
  a_burst_runs: assert property (@(posedge clk) disable iff (rst || cfg_we)
    (strobe && !last) |=> strobe)
    else $error("gap inside a result burst");

endmodule

### hdl/bipartite_byte_ring_buffer_core.sv
// an item taken at start waits in the front queue; the engine pops it when idle and registers its result
// write, query, remove and failed requests: one item per cycle while the engine is idle, one result each
// read and peek of n bytes: a burst of n results back to back, read through the single store read port
// a read or remove that empties region a then copies region b to offset zero
// results cannot be stalled by the receiver; the strobe marks each one for one cycle
// synchronous reset: buffer unallocated, both regions empty, no item in flight
module bipartite_byte_ring_buffer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bbrb_pkg::MODE_W-1:0]   mode,
  input  logic [bbrb_pkg::LEN_W-1:0]    length,
  input  logic [7:0]                    data_byte,
  input  logic                          first,
  input  logic                          cfg_we,
  input  logic [bbrb_pkg::SIZE_W-1:0]   cfg_wdata,
  output logic                          strobe,
  output logic [7:0]                    out_byte,
  output logic                          byte_valid,
  output logic                          last,
  output logic [1:0]                    status,
  output logic [bbrb_pkg::LEN_W-1:0]    count,
  output logic [bbrb_pkg::SIZE_W-1:0]   space,
  output logic [bbrb_pkg::SIZE_W-1:0]   fill,
  output logic [bbrb_pkg::SIZE_W-1:0]   contiguous
);

  // classified item travelling from the front queue to the engine
  logic          q_valid;
  logic          q_pop;
  bbrb_pkg::op_t q_op;

  // front: decodes mode, caps length, holds up to two items
  bbrb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .length    (length),
    .data_byte (data_byte),
    .first     (first),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop)
  );

  // back: region bookkeeping, byte store, burst output and compaction
  bbrb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop),
    .strobe     (strobe),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .status     (status),
    .count      (count),
    .space      (space),
    .fill       (fill),
    .contiguous (contiguous)
  );

endmodule
